>>> rtl/itda_pkg.sv
package itda_pkg;

	// default width of the signed input value
	localparam int VALUE_WIDTH_DEF = 32;

	// bits of the binary value folded into the bcd register per cycle
	localparam int STEP_BITS = 4;

	// entries of the queue between classifier and converter
	localparam int QUEUE_DEPTH = 2;

	localparam int CHAR_W = 8;
	localparam int CNT_W  = 4;
	localparam int NIBBLE_W = 4;

	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'd48;
	localparam logic [CHAR_W-1:0] CH_MINUS   = 8'd45;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;

	// bcd digit at or above this value gets the add-3 correction before a shift
	localparam logic [NIBBLE_W-1:0] BCD_ADJ_LIMIT = 4'd5;
	localparam logic [NIBBLE_W-1:0] BCD_ADJ       = 4'd3;

	// decimal digits that hold any w-bit unsigned value: floor(w*log10(2)) + 1
	function automatic int num_digits(input int w);
		return ((w * 1233) >> 12) + 1;
	endfunction

endpackage

>>> rtl/itda_in_if.sv
interface itda_in_if import itda_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

>>> rtl/itda_out_if.sv
interface itda_out_if import itda_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] text_char;
	logic              is_last;
	logic [CNT_W-1:0]  char_count;

	modport source (output valid, output text_char, output is_last, output char_count,
		input ready);
	modport sink (input valid, input text_char, input is_last, input char_count,
		output ready);
endinterface

>>> rtl/itda_front.sv
module itda_front import itda_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	itda_in_if.sink            number,
	output logic               q_valid,
	input  logic               q_ready,
	output logic [VALUE_WIDTH:0] q_data
);
	logic                   neg;
	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] mag;

	// sign split and unsigned magnitude, most negative value stays exact
	assign raw = number.value;
	assign neg = raw[VALUE_WIDTH-1];
	assign mag = neg ? (~raw + 1'b1) : raw;

	assign q_valid      = number.valid;
	assign q_data       = {neg, mag};
	assign number.ready = q_ready;
endmodule

>>> rtl/itda_fifo.sv
module itda_fifo import itda_pkg::*; #(
	parameter int WIDTH = VALUE_WIDTH_DEF + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(QUEUE_DEPTH);

	logic [QUEUE_DEPTH-1:0][WIDTH-1:0] mem_q;
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_QW-1:0] cnt_q;
	logic push;
	logic pop;

	assign in_ready  = (cnt_q != FULL_CNT);
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				mem_q[wr_q] <= in_data;
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			end
			// count holds when both or neither happen
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

>>> rtl/itda_conv.sv
module itda_conv import itda_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	localparam int NDIG = num_digits(VALUE_WIDTH),
	localparam int DCW  = $clog2(NDIG + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              in_neg,
	input  logic [VALUE_WIDTH-1:0]            in_mag,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              out_neg,
	output logic [NDIG-1:0][NIBBLE_W-1:0]     out_bcd,
	output logic [DCW-1:0]                    out_ndig
);
	localparam int STEPS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
	localparam int PW    = STEPS * STEP_BITS;
	localparam int SCW   = (STEPS > 1) ? $clog2(STEPS) : 1;

	typedef enum logic [1:0] {CV_IDLE, CV_RUN, CV_DONE} cv_state_t;

	cv_state_t state_q;
	logic [PW-1:0]                   sh_q;
	logic [NDIG-1:0][NIBBLE_W-1:0]   bcd_q;
	logic                            neg_q;
	logic [SCW-1:0]                  cnt_q;
	logic [PW-1:0]                   sh_n;
	logic [NDIG-1:0][NIBBLE_W-1:0]   bcd_n;

	// shift-add-3, STEP_BITS bits per cycle
	always_comb begin
		bcd_n = bcd_q;
		sh_n  = sh_q;
		for (int j = 0; j < STEP_BITS; j++) begin
			for (int k = 0; k < NDIG; k++) begin
				if (bcd_n[k] >= BCD_ADJ_LIMIT) begin
					bcd_n[k] = bcd_n[k] + BCD_ADJ;
				end
			end
			{bcd_n, sh_n} = {bcd_n, sh_n} << 1;
		end
	end

	// digit count: highest non-zero digit, at least one
	always_comb begin
		out_ndig = DCW'(1);
		for (int k = 0; k < NDIG; k++) begin
			if (bcd_q[k] != '0) begin
				out_ndig = DCW'(k + 1);
			end
		end
	end

	assign in_ready  = (state_q == CV_IDLE);
	assign out_valid = (state_q == CV_DONE);
	assign out_neg   = neg_q;
	assign out_bcd   = bcd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CV_IDLE;
		end else begin
			unique case (state_q)
				CV_IDLE: begin
					if (in_valid) begin
						sh_q    <= PW'(in_mag);
						bcd_q   <= '0;
						neg_q   <= in_neg;
						cnt_q   <= SCW'(STEPS - 1);
						state_q <= CV_RUN;
					end
				end
				CV_RUN: begin
					sh_q  <= sh_n;
					bcd_q <= bcd_n;
					if (cnt_q == '0) begin
						state_q <= CV_DONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				CV_DONE: begin
					if (out_ready) begin
						state_q <= CV_IDLE;
					end
				end
				default: begin
					state_q <= CV_IDLE;
				end
			endcase
		end
	end
endmodule

>>> rtl/itda_emit.sv
module itda_emit import itda_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	localparam int NDIG = num_digits(VALUE_WIDTH),
	localparam int DCW  = $clog2(NDIG + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_neg,
	input  logic [NDIG-1:0][NIBBLE_W-1:0] in_bcd,
	input  logic [DCW-1:0]                in_ndig,
	itda_out_if.source                    text
);
	localparam int IW  = (NDIG > 1) ? $clog2(NDIG) : 1;
	localparam int TW  = $clog2(NDIG + 2);
	localparam int CW  = (TW > CNT_W) ? TW : CNT_W;

	typedef enum logic [1:0] {EM_IDLE, EM_SIGN, EM_DIGIT, EM_NL} em_state_t;

	em_state_t state_q;
	logic [NDIG-1:0][NIBBLE_W-1:0] bcd_q;
	logic [IW-1:0]     idx_q;
	logic [CW-1:0]     total_q;
	logic              ov_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic [CNT_W-1:0]  count_q;
	logic              adv;
	em_state_t         ld_state;
	logic [IW-1:0]     ld_idx;
	logic [CW-1:0]     ld_total;
	logic [NIBBLE_W-1:0] digit;

	// output register is free, or its beat leaves this cycle
	assign adv      = (state_q != EM_IDLE) && (!ov_q || text.ready);
	assign in_ready = (state_q == EM_IDLE) || ((state_q == EM_NL) && adv);

	assign ld_state = in_neg ? EM_SIGN : EM_DIGIT;
	assign ld_idx   = IW'(in_ndig - DCW'(1));
	assign ld_total = CW'(in_ndig) + CW'(in_neg);
	assign digit    = bcd_q[idx_q];

	assign text.valid      = ov_q;
	assign text.text_char  = char_q;
	assign text.is_last    = last_q;
	assign text.char_count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EM_IDLE;
			ov_q    <= 1'b0;
		end else begin
			if (adv) begin
				ov_q <= 1'b1;
			end else if (text.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				EM_IDLE: begin
					if (in_valid) begin
						bcd_q   <= in_bcd;
						idx_q   <= ld_idx;
						total_q <= ld_total;
						state_q <= ld_state;
					end
				end
				EM_SIGN: begin
					if (adv) begin
						char_q  <= CH_MINUS;
						last_q  <= 1'b0;
						count_q <= '0;
						state_q <= EM_DIGIT;
					end
				end
				EM_DIGIT: begin
					if (adv) begin
						char_q  <= CH_ZERO + {{(CHAR_W - NIBBLE_W){1'b0}}, digit};
						last_q  <= 1'b0;
						count_q <= '0;
						if (idx_q == '0) begin
							state_q <= EM_NL;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				EM_NL: begin
					if (adv) begin
						char_q  <= CH_NEWLINE;
						last_q  <= 1'b1;
						count_q <= total_q[CNT_W-1:0];
						if (in_valid) begin
							bcd_q   <= in_bcd;
							idx_q   <= ld_idx;
							total_q <= ld_total;
							state_q <= ld_state;
						end else begin
							state_q <= EM_IDLE;
						end
					end
				end
				default: begin
					state_q <= EM_IDLE;
				end
			endcase
		end
	end
endmodule

>>> rtl/int_to_decimal_ascii_top.sv
// signed integer to decimal ascii text
//
// number: one beat carries a signed two's complement value of VALUE_WIDTH bits
// text:   one beat per character, most significant first: an optional '-', the
//         digits with no leading zeros ('0' for zero), then a newline beat with
//         is_last set and char_count giving the characters before it
//
// the first character waits on the bcd converter, which folds four bits per cycle
// throughput: one character per cycle on text within an item, while the receiver
// takes every beat
// a two-entry queue and the converter's result hold let new numbers be taken
// while text is still going out
// reset: all control state cleared, no beat in flight, nothing to sweep
// receiver stall: the output register holds its beat; the emitter, then the
// converter, then the queue fill, and number.ready drops once the queue is full
module int_to_decimal_ascii_top import itda_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	itda_in_if.sink    number,
	itda_out_if.source text
);
	localparam int NDIG = num_digits(VALUE_WIDTH);
	localparam int DCW  = $clog2(NDIG + 1);

	// front to queue
	logic                   fq_valid;
	logic                   fq_ready;
	logic [VALUE_WIDTH:0]   fq_data;

	// queue to converter
	logic                   qc_valid;
	logic                   qc_ready;
	logic [VALUE_WIDTH:0]   qc_data;

	// converter to emitter
	logic                          ce_valid;
	logic                          ce_ready;
	logic                          ce_neg;
	logic [NDIG-1:0][NIBBLE_W-1:0] ce_bcd;
	logic [DCW-1:0]                ce_ndig;

	// sign and magnitude split
	itda_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
		.number  (number),
		.q_valid (fq_valid),
		.q_ready (fq_ready),
		.q_data  (fq_data)
	);

	// short queue so the front keeps taking beats while the back is busy
	itda_fifo #(.WIDTH(VALUE_WIDTH + 1)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_data   (fq_data),
		.out_valid (qc_valid),
		.out_ready (qc_ready),
		.out_data  (qc_data)
	);

	// iterative binary to bcd, result held until the emitter takes it
	itda_conv #(.VALUE_WIDTH(VALUE_WIDTH)) u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (qc_valid),
		.in_ready  (qc_ready),
		.in_neg    (qc_data[VALUE_WIDTH]),
		.in_mag    (qc_data[VALUE_WIDTH-1:0]),
		.out_valid (ce_valid),
		.out_ready (ce_ready),
		.out_neg   (ce_neg),
		.out_bcd   (ce_bcd),
		.out_ndig  (ce_ndig)
	);

	// character sequencer with registered output beat
	itda_emit #(.VALUE_WIDTH(VALUE_WIDTH)) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (ce_valid),
		.in_ready (ce_ready),
		.in_neg   (ce_neg),
		.in_bcd   (ce_bcd),
		.in_ndig  (ce_ndig),
		.text     (text)
	);

`ifndef SYNTHESIS
	// a converted value always has at least one digit
	a_ndig_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(ce_valid && ce_ready) |-> (ce_ndig != '0))
		else $error("converter handed over a value with no digits");

	// the closing beat is the newline
	a_last_is_newline: assert property (@(posedge clk) disable iff (!arst_n)
		(text.valid && text.is_last) |-> (text.text_char == CH_NEWLINE))
		else $error("last beat is not a newline");

	// other beats carry no count and no newline
	a_body_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(text.valid && !text.is_last) |->
		((text.char_count == '0) && (text.text_char != CH_NEWLINE)))
		else $error("body beat carries a count or a newline");
`endif
endmodule
